FILE: hdl/mct_pkg.sv
// Shared types, field layouts and constants for the MIDI clock transport follower.
package mct_pkg;

   // Field widths.
   localparam int OP_W      = 3;
   localparam int TS_W      = 32;
   localparam int SPP_W     = 14;
   localparam int HZ_W      = 27;
   localparam int PULSE_W   = 5;
   localparam int BEATS_W   = 32;
   localparam int TEMPO_W   = 24;
   localparam int REQ_W     = 56;
   localparam int RSP_W     = 80;

   // Request data layout, lowest bit first.
   localparam int REQ_OP_LSB  = 0;
   localparam int REQ_TS_LSB  = REQ_OP_LSB + OP_W;
   localparam int REQ_SPP_LSB = REQ_TS_LSB + TS_W;
   localparam int REQ_USED_W  = REQ_SPP_LSB + SPP_W;

   // Response data layout, lowest bit first.
   localparam int RSP_RUN_BIT   = 0;
   localparam int RSP_PULSE_LSB = 1;
   localparam int RSP_BEATS_LSB = RSP_PULSE_LSB + PULSE_W;
   localparam int RSP_DONE_BIT  = RSP_BEATS_LSB + BEATS_W;
   localparam int RSP_TEMPO_LSB = RSP_DONE_BIT + 1;
   localparam int RSP_SPP_LSB   = RSP_TEMPO_LSB + TEMPO_W;
   localparam int RSP_USED_W    = RSP_SPP_LSB + SPP_W;

   // Tempo numerator is timestamp_hz * 60 s * 256 (Q8 scaling).
   localparam int TEMPO_SCALE = 60 * 256;
   localparam int NUM_W       = HZ_W + 14;
   localparam int NUM_LO_W    = TEMPO_W;
   localparam int NUM_HI_W    = NUM_W - NUM_LO_W;
   localparam int QCNT_W      = $clog2(TEMPO_W);

   localparam logic [HZ_W-1:0]    HZ_RESET  = HZ_W'(1000000);
   localparam logic [TEMPO_W-1:0] TEMPO_MAX = '1;
   localparam logic [BEATS_W-1:0] BEATS_MAX = '1;

   // Message codes.
   typedef enum logic [OP_W-1:0] {
      OP_CLOCK    = 3'd0,
      OP_START    = 3'd1,
      OP_CONTINUE = 3'd2,
      OP_STOP     = 3'd3,
      OP_SONG_POS = 3'd4,
      OP_RESET    = 3'd5
   } op_type;

   // Top-level sequencer states.
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_OUTPUT
   } ctl_state_type;

   // Divider sequencer states.
   typedef enum logic [1:0] {
      DIV_IDLE,
      DIV_CHECK,
      DIV_ITER
   } div_state_type;

   // Divider result as seen by the sequencer.
   typedef struct packed {
      logic                done;
      logic [TEMPO_W-1:0]  quotient;
   } div_result_type;

endpackage

FILE: hdl/midi_clock_transport_follower.sv
// Top level of the MIDI clock transport follower: transport state, sequencer and channels.
//
// Usage: each request transaction carries one decoded MIDI realtime message
// (operation, timestamp, song position) on req_tdata. Every request produces
// exactly one response transaction on rsp_tdata showing the transport state
// after that message.
// Messages other than a tempo-updating clock load the response register at
// the accepting edge, so the response is valid in the cycle after acceptance.
// A clock that refreshes the tempo runs the bit-serial divider: one overflow
// check plus 24 quotient steps on its shared subtractor, or the check alone
// when it saturates the tempo at once; the quotient is then loaded into the
// response register from ST_OUTPUT once the response register is free.
// Throughput: one message at a time; req_tready is low while a division runs.
// Reset clears the transport state, the tempo and the previous clock time,
// and sets timestamp_hz to 1000000. If the receiver stalls, the response is
// held in its register and a new request is taken only once it is consumed
// or in the cycle it is taken.
// csr_wr_en writes timestamp_hz; write it only while the block is idle.
module midi_clock_transport_follower
   import mct_pkg::*;
#(
   parameter int CLOCKS_PER_BEAT = 24
) (
   input  logic              clock,
   input  logic              reset,
   // Request: operation[2:0], timestamp[34:3], song_pointer_in[48:35], zero fill.
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [REQ_W-1:0]  req_tdata,
   // Response: running[0], clock_in_beat[5:1], beat_count[37:6], beat_done[38],
   // tempo_q8[62:39], song_pointer[76:63], zero fill.
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [RSP_W-1:0]  rsp_tdata,
   input  logic              csr_wr_en,
   input  logic [HZ_W-1:0]   csr_wr_data
);

   ctl_state_type         state_ff, state_in;
   logic [HZ_W-1:0]       hz_ff, hz_in;
   logic                  run_ff, run_in;
   logic [PULSE_W-1:0]    pulse_ff, pulse_in;
   logic [BEATS_W-1:0]    beats_ff, beats_in;
   logic [TS_W-1:0]       prev_ff, prev_in;
   logic [TEMPO_W-1:0]    tempo_ff, tempo_in;
   logic [SPP_W-1:0]      spp_ff, spp_in;
   logic                  done_ff, done_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_W-1:0]      rsp_data_ff, rsp_data_in;

   op_type                op;
   logic [TS_W-1:0]       ts;
   logic [SPP_W-1:0]      spp;
   logic                  out_free;
   logic                  accept;
   logic                  tempo_upd;
   logic                  div_start;
   logic                  load_out;
   logic [PULSE_W-1:0]    pulse_inc;
   logic [TS_W-1:0]       interval;
   div_result_type        div_res;

   // Request fields.
   assign op  = op_type'(req_tdata[REQ_OP_LSB +: OP_W]);
   assign ts  = req_tdata[REQ_TS_LSB +: TS_W];
   assign spp = req_tdata[REQ_SPP_LSB +: SPP_W];

   assign out_free  = ~rsp_valid_ff | rsp_tready;
   assign accept    = req_tvalid & req_tready;
   assign interval  = ts - prev_ff;
   assign pulse_inc = pulse_ff + PULSE_W'(1);
   assign tempo_upd = run_ff & (op == OP_CLOCK) & (prev_ff != '0) & (ts > prev_ff);
   assign div_start = accept & tempo_upd;

   mct_divider #(
      .CLOCKS_PER_BEAT (CLOCKS_PER_BEAT)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .hz       (hz_ff),
      .interval (interval),
      .result   (div_res)
   );

   // Next state of the sequencer.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (div_start) begin
               state_in = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            if (div_res.done) begin
               state_in = ST_OUTPUT;
            end
         end
         ST_OUTPUT: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Sequencer outputs.
   always_comb begin
      req_tready = 1'b0;
      load_out   = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = out_free;
            load_out   = accept & ~tempo_upd;
         end
         ST_DIVIDE: begin
            load_out = 1'b0;
         end
         ST_OUTPUT: begin
            load_out = out_free;
         end
         default: begin
            req_tready = 1'b0;
         end
      endcase
   end

   // Transport state updates per message.
   always_comb begin
      run_in   = run_ff;
      pulse_in = pulse_ff;
      beats_in = beats_ff;
      prev_in  = prev_ff;
      tempo_in = tempo_ff;
      spp_in   = spp_ff;
      done_in  = done_ff;
      if (accept) begin
         done_in = 1'b0;
         case (op)
            OP_CLOCK: begin
               if (run_ff) begin
                  prev_in = ts;
                  if (pulse_inc >= PULSE_W'(CLOCKS_PER_BEAT)) begin
                     pulse_in = '0;
                     done_in  = 1'b1;
                     if (beats_ff != BEATS_MAX) begin
                        beats_in = beats_ff + BEATS_W'(1);
                     end
                  end else begin
                     pulse_in = pulse_inc;
                  end
               end
            end
            OP_START: begin
               run_in   = 1'b1;
               pulse_in = '0;
               beats_in = '0;
               spp_in   = '0;
            end
            OP_CONTINUE: begin
               run_in = 1'b1;
            end
            OP_STOP: begin
               run_in = 1'b0;
            end
            OP_SONG_POS: begin
               spp_in = spp;
            end
            OP_RESET: begin
               run_in   = 1'b0;
               pulse_in = '0;
               beats_in = '0;
               spp_in   = '0;
               tempo_in = '0;
            end
            default: begin
               run_in = run_ff;
            end
         endcase
      end
      if (state_ff == ST_DIVIDE && div_res.done) begin
         tempo_in = div_res.quotient;
      end
   end

   // Configuration register.
   assign hz_in = csr_wr_en ? csr_wr_data : hz_ff;

   // Response register: load the state after the message, clear once taken.
   always_comb begin
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      if (load_out) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = '0;
         rsp_data_in[RSP_RUN_BIT]             = run_in;
         rsp_data_in[RSP_PULSE_LSB +: PULSE_W] = pulse_in;
         rsp_data_in[RSP_BEATS_LSB +: BEATS_W] = beats_in;
         rsp_data_in[RSP_DONE_BIT]            = done_in;
         rsp_data_in[RSP_TEMPO_LSB +: TEMPO_W] = tempo_in;
         rsp_data_in[RSP_SPP_LSB +: SPP_W]     = spp_in;
      end
   end

   // Control and transport state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         hz_ff        <= HZ_RESET;
         run_ff       <= 1'b0;
         pulse_ff     <= '0;
         beats_ff     <= '0;
         prev_ff      <= '0;
         tempo_ff     <= '0;
         spp_ff       <= '0;
         done_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         hz_ff        <= hz_in;
         run_ff       <= run_in;
         pulse_ff     <= pulse_in;
         beats_ff     <= beats_in;
         prev_ff      <= prev_in;
         tempo_ff     <= tempo_in;
         spp_ff       <= spp_in;
         done_ff      <= done_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Response payload.
   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

FILE: hdl/mct_divider.sv
// Bit-serial tempo divider built around one shared subtract-and-compare unit.
module mct_divider
   import mct_pkg::*;
#(
   parameter int CLOCKS_PER_BEAT = 24
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [HZ_W-1:0]      hz,
   input  logic [TS_W-1:0]      interval,
   output div_result_type       result
);

   localparam int DEN_W = TS_W + $clog2(CLOCKS_PER_BEAT + 1);

   div_state_type          state_ff, state_in;
   logic [NUM_HI_W-1:0]    hi_ff, hi_in;
   logic [NUM_LO_W-1:0]    lo_ff, lo_in;
   logic [DEN_W-1:0]       den_ff, den_in;
   logic [DEN_W-1:0]       rem_ff, rem_in;
   logic [TEMPO_W-1:0]     quot_ff, quot_in;
   logic [QCNT_W-1:0]      cnt_ff, cnt_in;
   logic                   done_ff, done_in;

   logic [NUM_W-1:0]       num;
   logic [DEN_W:0]         opa;
   logic [DEN_W:0]         diff;
   logic                   ge;

   // Operands scaled by constants at start.
   assign num = NUM_W'(hz) * NUM_W'(TEMPO_SCALE);

   // Shared unit: the overflow check and every quotient step use this one subtractor.
   always_comb begin
      if (state_ff == DIV_CHECK) begin
         opa = (DEN_W + 1)'(hi_ff);
      end else begin
         opa = {rem_ff, lo_ff[NUM_LO_W-1]};
      end
      diff = opa - {1'b0, den_ff};
      ge   = ~diff[DEN_W];
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         DIV_IDLE: begin
            if (start) begin
               state_in = DIV_CHECK;
            end
         end
         DIV_CHECK: begin
            state_in = ge ? DIV_IDLE : DIV_ITER;
         end
         DIV_ITER: begin
            if (cnt_ff == '0) begin
               state_in = DIV_IDLE;
            end
         end
         default: state_in = DIV_IDLE;
      endcase
   end

   // Datapath updates for each state.
   always_comb begin
      hi_in   = hi_ff;
      lo_in   = lo_ff;
      den_in  = den_ff;
      rem_in  = rem_ff;
      quot_in = quot_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      case (state_ff)
         DIV_IDLE: begin
            if (start) begin
               hi_in  = num[NUM_W-1:NUM_LO_W];
               lo_in  = num[NUM_LO_W-1:0];
               den_in = DEN_W'(interval) * DEN_W'(CLOCKS_PER_BEAT);
               cnt_in = QCNT_W'(TEMPO_W - 1);
            end
         end
         DIV_CHECK: begin
            // A quotient of 2^24 or more saturates at once.
            if (ge) begin
               quot_in = TEMPO_MAX;
               done_in = 1'b1;
            end else begin
               rem_in = opa[DEN_W-1:0];
            end
         end
         DIV_ITER: begin
            rem_in  = ge ? diff[DEN_W-1:0] : opa[DEN_W-1:0];
            quot_in = {quot_ff[TEMPO_W-2:0], ge};
            lo_in   = {lo_ff[NUM_LO_W-2:0], 1'b0};
            cnt_in  = cnt_ff - QCNT_W'(1);
            if (cnt_ff == '0) begin
               done_in = 1'b1;
            end
         end
         default: begin
            done_in = 1'b0;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= DIV_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      hi_ff   <= hi_in;
      lo_ff   <= lo_in;
      den_ff  <= den_in;
      rem_ff  <= rem_in;
      quot_ff <= quot_in;
      cnt_ff  <= cnt_in;
   end

   assign result.done     = done_ff;
   assign result.quotient = quot_ff;

endmodule

FILE: hdl/mct_checker.sv
// Port-level checks of the MIDI clock transport follower, bound to the top level.
module mct_checker
   import mct_pkg::*;
#(
   parameter int CLOCKS_PER_BEAT = 24
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   input  logic              req_tready,
   input  logic              rsp_tvalid,
   input  logic              rsp_tready,
   input  logic [RSP_W-1:0]  rsp_tdata
);

   // A stalled response transaction keeps its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response changed while stalled");

   // No response is pending straight after reset.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid after reset");

   // A request is only taken when the response register can take its result.
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |-> !rsp_tvalid || rsp_tready)
      else $error("request accepted over a blocked response");

   // A completed beat wraps the pulse count and implies a running transport.
   a_beat_wrap: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[RSP_DONE_BIT] |->
         rsp_tdata[RSP_PULSE_LSB +: PULSE_W] == '0 && rsp_tdata[RSP_RUN_BIT])
      else $error("beat completed without wrap");

   // The pulse count always stays below the clocks per beat.
   a_pulse_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[RSP_PULSE_LSB +: PULSE_W] < PULSE_W'(CLOCKS_PER_BEAT))
      else $error("pulse count out of range");

endmodule

bind midi_clock_transport_follower mct_checker #(
   .CLOCKS_PER_BEAT (CLOCKS_PER_BEAT)
) u_mct_checker (.*);

FILE: tb/sv/testbench.sv
// Self-checking testbench for the MIDI clock transport follower.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import mct_pkg::*;

   localparam int BEAT_CLOCKS = 24;
   localparam int STALL_LIMIT = 3000;
   localparam int SETTLE_CYCLES = 32;
   localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd6;
   localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;
   localparam logic [SPP_W-1:0] SPP_MAX = '1;
   localparam logic [TS_W-1:0] TS_MAX = '1;

   // Transport state as reported by one response transaction.
   typedef struct {
      logic               running;
      logic [PULSE_W-1:0] clock_in_beat;
      logic [BEATS_W-1:0] beat_count;
      logic               beat_done;
      logic [TEMPO_W-1:0] tempo_q8;
      logic [SPP_W-1:0]   song_pointer;
   } transport_report_type;

   // Tracks the transport state and holds the reports still to arrive.
   class transport_tracker;
      logic [HZ_W-1:0]    tick_rate;
      logic               running;
      logic [PULSE_W-1:0] pulses;
      logic [BEATS_W-1:0] beats;
      logic [TS_W-1:0]    last_clock_time;
      logic [TEMPO_W-1:0] tempo;
      logic [SPP_W-1:0]   position;
      transport_report_type pending_reports[$];
      int                 errors;
      int                 checked;
      int                 beats_seen;
      int                 tempo_refreshes;

      function new();
         tick_rate = HZ_RESET;
         running = 1'b0;
         pulses = '0;
         beats = '0;
         last_clock_time = '0;
         tempo = '0;
         position = '0;
         errors = 0;
         checked = 0;
         beats_seen = 0;
         tempo_refreshes = 0;
      endfunction

      function void set_tick_rate(logic [HZ_W-1:0] rate);
         tick_rate = rate;
      endfunction

      // Beats per minute in Q16.8 from the clock interval, saturating.
      function logic [TEMPO_W-1:0] bpm_q8(logic [TS_W-1:0] interval);
         logic [63:0] numerator;
         logic [63:0] denominator;
         logic [63:0] quotient;
         numerator = 64'(TEMPO_SCALE) * 64'(tick_rate);
         denominator = 64'(interval) * 64'(BEAT_CLOCKS);
         if (denominator == 0) return TEMPO_MAX;
         quotient = numerator / denominator;
         if (quotient > 64'(TEMPO_MAX)) return TEMPO_MAX;
         return quotient[TEMPO_W-1:0];
      endfunction

      // Applies one accepted message and queues the report it should cause.
      function void note_message(logic [OP_W-1:0] op, logic [TS_W-1:0] ts,
                                 logic [SPP_W-1:0] spp);
         transport_report_type report;
         logic done;
         done = 1'b0;
         case (op)
            OP_CLOCK: begin
               // A clock while stopped changes nothing at all.
               if (running) begin
                  if (last_clock_time != 0 && ts > last_clock_time) begin
                     tempo = bpm_q8(ts - last_clock_time);
                     tempo_refreshes++;
                  end
                  last_clock_time = ts;
                  if (pulses + 1 >= BEAT_CLOCKS) begin
                     pulses = '0;
                     if (beats != BEATS_MAX) beats = beats + BEATS_W'(1);
                     done = 1'b1;
                     beats_seen++;
                  end else begin
                     pulses = pulses + PULSE_W'(1);
                  end
               end
            end
            OP_START: begin
               running = 1'b1;
               pulses = '0;
               beats = '0;
               position = '0;
            end
            OP_CONTINUE: running = 1'b1;
            OP_STOP: running = 1'b0;
            OP_SONG_POS: position = spp;
            OP_RESET: begin
               // The previous clock time survives a reset message.
               running = 1'b0;
               pulses = '0;
               beats = '0;
               position = '0;
               tempo = '0;
            end
            default: ;
         endcase
         report.running = running;
         report.clock_in_beat = pulses;
         report.beat_count = beats;
         report.beat_done = done;
         report.tempo_q8 = tempo;
         report.song_pointer = position;
         pending_reports.push_back(report);
      endfunction

      function void compare_field(string name, logic [BEATS_W-1:0] want,
                                  logic [BEATS_W-1:0] got);
         if (got !== want) begin
            $error("%s: expected %0h, actual %0h", name, want, got);
            errors++;
         end
      endfunction

      // Compares one accepted response with the oldest pending report.
      function void check_report(logic [RSP_W-1:0] data);
         transport_report_type want;
         if (pending_reports.size() == 0) begin
            $error("response %h arrived with no message outstanding", data);
            errors++;
            return;
         end
         want = pending_reports.pop_front();
         checked++;
         compare_field("running", BEATS_W'(want.running), BEATS_W'(data[RSP_RUN_BIT]));
         compare_field("clock_in_beat", BEATS_W'(want.clock_in_beat),
                       BEATS_W'(data[RSP_PULSE_LSB +: PULSE_W]));
         compare_field("beat_count", want.beat_count, data[RSP_BEATS_LSB +: BEATS_W]);
         compare_field("beat_done", BEATS_W'(want.beat_done),
                       BEATS_W'(data[RSP_DONE_BIT]));
         compare_field("tempo_q8", BEATS_W'(want.tempo_q8),
                       BEATS_W'(data[RSP_TEMPO_LSB +: TEMPO_W]));
         compare_field("song_pointer", BEATS_W'(want.song_pointer),
                       BEATS_W'(data[RSP_SPP_LSB +: SPP_W]));
      endfunction
   endclass

   logic              clock;
   logic              reset;
   logic              req_tvalid;
   logic              req_tready;
   logic [REQ_W-1:0]  req_tdata;
   logic              rsp_tvalid;
   logic              rsp_tready;
   logic [RSP_W-1:0]  rsp_tdata;
   logic              csr_wr_en;
   logic [HZ_W-1:0]   csr_wr_data;

   transport_tracker tracker = new();
   bit               steady;
   logic [TS_W-1:0]  clock_time;
   int               messages_sent;
   int               rates_used;
   int               quiet_cycles;

   midi_clock_transport_follower #(
      .CLOCKS_PER_BEAT(BEAT_CLOCKS)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .csr_wr_en(csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // The receiver stalls at random, except through the steady stretch.
   always @(posedge clock) begin
      rsp_tready <= steady || ($urandom_range(99) >= 33);
   end

   // Response checking and the watchdog on cycles without any transaction.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) tracker.check_report(rsp_tdata);
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("testbench failed");
         $finish;
      end
   end

   // Offers one message, with a random gap beforehand, and notes it once taken.
   task automatic send_message(logic [OP_W-1:0] op, logic [TS_W-1:0] ts,
                               logic [SPP_W-1:0] spp);
      logic [REQ_W-1:0] data;
      int gap;
      data = '0;
      data[REQ_OP_LSB +: OP_W] = op;
      data[REQ_TS_LSB +: TS_W] = ts;
      data[REQ_SPP_LSB +: SPP_W] = spp;
      gap = 0;
      if (!steady) begin
         while (gap < 20 && $urandom_range(99) < 33) gap++;
      end
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tdata <= data;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      tracker.note_message(op, ts, spp);
      messages_sent++;
   endtask

   // Holds the sender back until every outstanding report has been checked.
   task automatic await_quiet(int settle);
      req_tvalid <= 1'b0;
      do @(posedge clock); while (tracker.pending_reports.size() > 0);
      repeat (settle) @(posedge clock);
   endtask

   // Writes the tick rate once the block has gone idle.
   task automatic write_tick_rate(logic [HZ_W-1:0] rate);
      await_quiet(SETTLE_CYCLES);
      csr_wr_data <= rate;
      csr_wr_en <= 1'b1;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      tracker.set_tick_rate(rate);
      rates_used++;
   endtask

   // A transport session: Start, then mostly clocks at a steady period with
   // some repeated, backward and arbitrary timestamps and other messages mixed in.
   task automatic play_session(int count);
      logic [TS_W-1:0] period;
      int pick;
      case ($urandom_range(2))
         0: period = $urandom_range(1, 64);
         1: period = $urandom_range(100, 200000);
         default: period = $urandom_range(1000000, 100000000);
      endcase
      send_message(OP_START, $urandom(), SPP_W'($urandom_range(SPP_MAX)));
      for (int i = 1; i < count; i++) begin
         pick = $urandom_range(99);
         if (pick < 80) begin
            case ($urandom_range(9))
               0: ;
               1: clock_time = clock_time - $urandom_range(1, period);
               2: clock_time = $urandom();
               default: clock_time = clock_time + period - period / 16
                                     + $urandom_range(period / 8);
            endcase
            send_message(OP_CLOCK, clock_time, SPP_W'($urandom_range(SPP_MAX)));
         end else if (pick < 85) begin
            send_message(OP_STOP, $urandom(), SPP_W'($urandom_range(SPP_MAX)));
         end else if (pick < 90) begin
            send_message(OP_CONTINUE, $urandom(), SPP_W'($urandom_range(SPP_MAX)));
         end else if (pick < 94) begin
            send_message(OP_SONG_POS, $urandom(), SPP_W'($urandom_range(SPP_MAX)));
         end else if (pick < 96) begin
            send_message(OP_START, $urandom(), SPP_W'($urandom_range(SPP_MAX)));
         end else if (pick < 98) begin
            send_message(OP_RESET, $urandom(), SPP_W'($urandom_range(SPP_MAX)));
         end else begin
            send_message(pick[0] ? OP_SPARE_HI : OP_SPARE_LO, $urandom(),
                         SPP_W'($urandom_range(SPP_MAX)));
         end
      end
   endtask

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      rsp_tready = 1'b0;
      csr_wr_en = 1'b0;
      csr_wr_data = '0;
      steady = 1'b0;
      clock_time = '0;
      messages_sent = 0;
      rates_used = 0;
      quiet_cycles = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed: ignored codes, clocks while stopped, first clock, repeated and
      // backward timestamps, tempo saturation, the reset message and field extremes.
      send_message(OP_SPARE_LO, '0, SPP_MAX);
      send_message(OP_SPARE_HI, TS_MAX, '0);
      send_message(OP_CLOCK, 32'd1000, '0);
      send_message(OP_SONG_POS, 32'd7, SPP_MAX);
      send_message(OP_START, '0, '0);
      send_message(OP_CLOCK, '0, '0);
      send_message(OP_CLOCK, 32'd20833, '0);
      send_message(OP_CLOCK, 32'd41666, '0);
      send_message(OP_CLOCK, 32'd41666, '0);
      send_message(OP_CLOCK, 32'd30000, '0);
      send_message(OP_CLOCK, 32'd30001, '0);
      send_message(OP_CLOCK, TS_MAX, SPP_MAX);
      send_message(OP_SONG_POS, 32'd9, 14'h2aaa);
      send_message(OP_SONG_POS, 32'd9, 14'h1555);
      send_message(OP_STOP, '0, '0);
      send_message(OP_CLOCK, 32'd5, '0);
      send_message(OP_CONTINUE, '0, '0);
      send_message(OP_CLOCK, 32'd10, '0);
      send_message(OP_RESET, '0, '0);
      send_message(OP_CLOCK, 32'd15, '0);
      send_message(OP_START, '0, '0);
      send_message(OP_CLOCK, 32'd20, '0);

      // A tick rate of zero must give a tempo of zero.
      write_tick_rate('0);
      send_message(OP_CLOCK, 32'd120, '0);
      send_message(OP_CLOCK, 32'd220, '0);

      // Random sessions at the range ends and at random tick rates.
      write_tick_rate(HZ_W'(1000));
      play_session(90);
      write_tick_rate(HZ_W'(100000000));
      steady = 1'b1;
      play_session(90);
      steady = 1'b0;
      write_tick_rate(HZ_W'($urandom_range(1000, 100000000)));
      play_session(45);
      await_quiet(0);
      play_session(45);
      write_tick_rate(HZ_W'($urandom_range(1000, 100000000)));
      play_session(90);
      write_tick_rate(HZ_RESET);
      play_session(90);

      await_quiet(40);
      $display("Sent %0d messages under %0d tick rates, zero and both range ends among them.",
               messages_sent, rates_used + 1);
      $display("Checked %0d responses with %0d completed beats and %0d tempo refreshes.",
               tracker.checked, tracker.beats_seen, tracker.tempo_refreshes);
      if (tracker.errors == 0) begin
         $display("testbench passed");
      end else begin
         $display("testbench failed");
      end
      $finish;
   end

endmodule

FILE: files.f
hdl/mct_pkg.sv
hdl/mct_divider.sv
hdl/midi_clock_transport_follower.sv
hdl/mct_checker.sv
tb/sv/testbench.sv
